// File: rtl/core/brainfuck_instruction_executor_macros.svh
// Assertion macros for the Brainfuck executor core.
// No dependencies; included by files that carry concurrent checks.
`ifndef BRAINFUCK_INSTRUCTION_EXECUTOR_MACROS_SVH
`define BRAINFUCK_INSTRUCTION_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bie_pkg.sv
// Shared types and command codes for the Brainfuck executor.
// No dependencies.
package bie_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] err_t;

  // command characters
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_LT    = 8'h3C;
  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_LBR   = 8'h5B;
  localparam byte_t CH_RBR   = 8'h5D;
  localparam byte_t CH_DOT   = 8'h2E;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_NL    = 8'h0A;

  localparam byte_t EOF_BYTE = 8'hFF;

  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_UNMATCHED = 2'd1;
  localparam err_t ERR_OVERFLOW  = 2'd2;

  localparam logic [15:0] SKIP_MAX = 16'hFFFF;

endpackage

// File: rtl/core/bie_instr_if.sv
// Instruction channel: program character plus input stream state.
// Depends on bie_pkg.
interface bie_instr_if;
  import bie_pkg::*;

  logic  valid;
  logic  ready;
  byte_t instr_char;
  logic  program_end;
  byte_t in_byte;
  logic  in_eof;

  modport source (output valid, instr_char, program_end, in_byte, in_eof, input ready);
  modport sink (input valid, instr_char, program_end, in_byte, in_eof, output ready);
endinterface

// File: rtl/core/bie_result_if.sv
// Result channel: next fetch address, output byte and status.
// Depends on bie_pkg.
interface bie_result_if;
  import bie_pkg::*;

  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        out_valid;
  byte_t       out_byte;
  logic        in_consumed;
  err_t        error_code;

  modport source (output valid, next_pc, out_valid, out_byte, in_consumed, error_code,
                  input ready);
  modport sink (input valid, next_pc, out_valid, out_byte, in_consumed, error_code,
                output ready);
endinterface

// File: rtl/core/bie_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// Read during write to the same address returns the old data. No dependencies.
module bie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/core/brainfuck_instruction_executor.sv
// Brainfuck instruction executor: top level with tape and loop-stack RAMs.
// Depends on bie_pkg, bie_instr_if, bie_result_if, bie_ram and the macros header.
//
//   channel  | dir | transfer carries
//   ---------+-----+---------------------------------------------------------
//   instr    | in  | instr_char, program_end, in_byte, in_eof
//   result   | out | next_pc, out_valid, out_byte, in_consumed, error_code
//
// One instruction per cycle sustained while results are taken: accept reads tape and
// stack RAM, the execute stage then works from the registered read data and writes back.
// Result valid is registered, set when the executing item completes into a free
// output register. An item may be accepted in the same cycle that the previous
// one executes (head/count bypassed, RAM data fwd). After reset a clearing pass
// zeroes the tape with ready low. A stalled result holds the executing item; the
// input stalls behind it.
module brainfuck_instruction_executor #(
  parameter int TAPE_DEPTH  = 32768,
  parameter int STACK_DEPTH = 64,
  parameter int PC_BITS     = 16
) (
  input logic clk,
  input logic rst,
  bie_instr_if.sink    instr,
  bie_result_if.source result
);
  import bie_pkg::*;
`include "brainfuck_instruction_executor_macros.svh"

  localparam int HW  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam logic [HW-1:0]  HEAD_LAST = HW'(TAPE_DEPTH - 1);
  localparam logic [SCW-1:0] CNT_FULL  = SCW'(STACK_DEPTH);

  // architectural state
  logic [HW-1:0]      head, head_next;
  logic [PC_BITS-1:0] pc, pc_next;
  logic [SCW-1:0]     cnt, cnt_next;
  logic [15:0]        skip, skip_next;

  // tape clearing pass
  logic          clr;
  logic [HW-1:0] clr_addr;

  // execute stage: item whose RAM reads are in flight / landed
  logic  x_vld;
  byte_t x_char, x_byte;
  logic  x_end, x_eof;

  // output register
  logic               o_vld;
  logic [PC_BITS-1:0] o_pc;
  logic               o_out_valid, o_consumed;
  byte_t              o_byte;
  err_t               o_err;

  logic o_free, x_done, accept;

  // RAM ports
  byte_t              tape_rdata, tape_wdata_x, tape_wdata;
  logic               tape_we_x, tape_we;
  logic [HW-1:0]      tape_waddr;
  logic [PC_BITS-1:0] stk_rdata;
  logic               push;
  logic [SAW-1:0]     stk_waddr, stk_raddr;
  logic [SCW-1:0]     cnt_dec;

  // forwarding of a write that lands in the read cycle
  logic               t_fwd, s_fwd;
  byte_t              t_fwd_data;
  logic [PC_BITS-1:0] s_fwd_data;
  byte_t              cur_cell;
  logic [PC_BITS-1:0] tos;

  // exec result
  logic  r_out_valid, r_consumed;
  byte_t r_byte;
  err_t  r_err;

  logic [PC_BITS+15:0] pc_ext;

  assign o_free       = !o_vld || result.ready;
  assign x_done       = x_vld && o_free;
  assign instr.ready  = !clr && (!x_vld || x_done);
  assign accept       = instr.valid && instr.ready;

  assign cur_cell = t_fwd ? t_fwd_data : tape_rdata;
  assign tos      = s_fwd ? s_fwd_data : stk_rdata;

  // execute: next state and result of the item in the execute stage
  always_comb begin
    head_next    = head;
    pc_next      = pc + 1'b1;
    cnt_next     = cnt;
    skip_next    = skip;
    tape_we_x    = 1'b0;
    tape_wdata_x = cur_cell;
    push         = 1'b0;
    r_out_valid  = 1'b0;
    r_byte       = '0;
    r_consumed   = 1'b0;
    r_err        = ERR_NONE;
    if (x_vld) begin
      priority if (x_end) begin
        pc_next     = '0;
        r_out_valid = 1'b1;
        r_byte      = CH_NL;
        cnt_next    = '0;
        skip_next   = '0;
      end else if (skip != '0) begin
        // skipping a loop body: only brackets count
        if (x_char == CH_LBR) begin
          if (skip != SKIP_MAX) begin
            skip_next = skip + 1'b1;
          end
        end else if (x_char == CH_RBR) begin
          skip_next = skip - 1'b1;
        end
      end else begin
        unique case (x_char)
          CH_PLUS: begin
            tape_we_x    = 1'b1;
            tape_wdata_x = cur_cell + 1'b1;
          end
          CH_MINUS: begin
            tape_we_x    = 1'b1;
            tape_wdata_x = cur_cell - 1'b1;
          end
          CH_DOT: begin
            r_out_valid = 1'b1;
            r_byte      = cur_cell;
          end
          CH_COMMA: begin
            tape_we_x    = 1'b1;
            tape_wdata_x = x_eof ? EOF_BYTE : x_byte;
            r_consumed   = !x_eof;
          end
          CH_LT: begin
            head_next = (head == '0) ? HEAD_LAST : head - 1'b1;
          end
          CH_GT: begin
            head_next = (head >= HEAD_LAST) ? '0 : head + 1'b1;
          end
          CH_LBR: begin
            if (cur_cell == '0) begin
              skip_next = 16'd1;
            end else if (cnt >= CNT_FULL) begin
              r_err = ERR_OVERFLOW;
            end else begin
              push     = 1'b1;
              cnt_next = cnt + 1'b1;
            end
          end
          CH_RBR: begin
            if (cnt == '0) begin
              r_err = ERR_UNMATCHED;
            end else if (cur_cell == '0) begin
              cnt_next = cnt - 1'b1;
            end else begin
              pc_next = tos;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // read addresses use post-execute head and count (bypass)
  assign cnt_dec   = cnt_next - 1'b1;
  assign stk_raddr = cnt_dec[SAW-1:0];
  assign stk_waddr = cnt[SAW-1:0];

  assign tape_we    = clr || (x_done && tape_we_x);
  assign tape_waddr = clr ? clr_addr : head;
  assign tape_wdata = clr ? byte_t'(0) : tape_wdata_x;

  bie_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .re    (accept),
    .raddr (head_next),
    .rdata (tape_rdata)
  );

  bie_ram #(.WIDTH(PC_BITS), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (x_done && push),
    .waddr (stk_waddr),
    .wdata (pc_next),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr      <= 1'b1;
      clr_addr <= '0;
      x_vld    <= 1'b0;
      o_vld    <= 1'b0;
      head     <= '0;
      pc       <= '0;
      cnt      <= '0;
      skip     <= '0;
    end else begin
      if (clr) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == HEAD_LAST) begin
          clr <= 1'b0;
        end
      end
      if (accept) begin
        x_vld <= 1'b1;
      end else if (x_done) begin
        x_vld <= 1'b0;
      end
      if (x_done) begin
        o_vld <= 1'b1;
        head  <= head_next;
        pc    <= pc_next;
        cnt   <= cnt_next;
        skip  <= skip_next;
      end else if (result.ready) begin
        o_vld <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_char     <= instr.instr_char;
      x_end      <= instr.program_end;
      x_byte     <= instr.in_byte;
      x_eof      <= instr.in_eof;
      // a same-cycle write to the entry being read returns old data: forward it
      t_fwd      <= x_done && tape_we_x && (head == head_next);
      t_fwd_data <= tape_wdata_x;
      s_fwd      <= x_done && push && (stk_waddr == stk_raddr);
      s_fwd_data <= pc_next;
    end
    if (x_done) begin
      o_pc        <= pc_next;
      o_out_valid <= r_out_valid;
      o_byte      <= r_byte;
      o_consumed  <= r_consumed;
      o_err       <= r_err;
    end
  end

  assign pc_ext             = {16'b0, o_pc};
  assign result.valid       = o_vld;
  assign result.next_pc     = pc_ext[15:0];
  assign result.out_valid   = o_out_valid;
  assign result.out_byte    = o_byte;
  assign result.in_consumed = o_consumed;
  assign result.error_code  = o_err;

  `BIE_ASSERT_NOW(a_no_accept_in_clear, clk, rst, clr, !instr.ready, "accept during tape clear")
  `BIE_ASSERT_NOW(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_FULL, "loop stack count overflow")
  `BIE_ASSERT_NOW(a_head_bound, clk, rst, 1'b1, head <= HEAD_LAST, "tape head out of range")
  `BIE_ASSERT_NEXT(a_hold_exec, clk, rst, x_vld && !o_free, x_vld && $stable(x_char), "exec item lost while stalled")
  `BIE_ASSERT_NOW(a_skip_no_write, clk, rst, x_vld && !x_end && skip != '0, !tape_we_x && !push, "state change while skipping")
endmodule
